@@ sv/ser_pkg.sv @@
// ----------------------------------------------------------------------------
// ser_pkg
// Shared types and constants of the multi-channel sonar echo ranger.
// ----------------------------------------------------------------------------
package ser_pkg;

    localparam int TS_W      = 32;
    localparam int DIST_W    = 16;
    localparam int OUT_CH_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [31:0] SCALE_RESET   = 32'd1535;
    localparam logic [15:0] MAX_DIST_RESET = 16'd4000;
    localparam logic [31:0] TIMEOUT_RESET = 32'd19200000;

    // mode field codes
    localparam logic MODE_TRIGGER = 1'b0;
    localparam logic MODE_ECHO    = 1'b1;
    // level field codes
    localparam logic LEVEL_RISE   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE    = 2'd0,
        CFG_MAX_DIST = 2'd1,
        CFG_TIMEOUT  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic                mode;
        logic [OUT_CH_W-1:0] channel;
        logic                level;
        logic [TS_W-1:0]     timestamp;
    } item_t;

    typedef struct packed {
        logic [OUT_CH_W-1:0] out_channel;
        logic [DIST_W-1:0]   distance_mm;
        logic                reading_valid;
        logic                last_of_run;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MULT,
        ST_ECHO_OUT,
        ST_TRIG_WALK
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // latch the accepted item
        logic store_rise;   // rising edge: keep its timestamp
        logic mult;         // width * scale, keep upper word
        logic echo_commit;  // clamp, hold reading, emit one result
        logic trig_step;    // time-out check and emit for one channel
    } ser_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_trigger;
        logic ch_ok;
        logic is_rise;
        logic last_ch;
        logic out_free;
    } ser_status_t;

endpackage

@@ sv/ser_ctrl.sv @@
// ----------------------------------------------------------------------------
// ser_ctrl
// Sequencer: accepts an item, decodes it and steps the datapath.
// ----------------------------------------------------------------------------
module ser_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  ser_pkg::ser_status_t  status,
    output ser_pkg::ser_cmd_t     cmd
);
    import ser_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_trigger)
                begin
                    state_next = ST_TRIG_WALK;
                end
                else if (!status.ch_ok)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.is_rise)
                begin
                    cmd.store_rise = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_ECHO_OUT;
            end
            ST_ECHO_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.echo_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_TRIG_WALK:
            begin
                if (status.out_free)
                begin
                    cmd.trig_step = 1'b1;
                    if (status.last_ch)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // results are only launched into a free output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.echo_commit || cmd.trig_step) |-> status.out_free)
        else $error("result launched into a busy output register");

    // the walk ends after the last channel
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.trig_step && status.last_ch) |=> (state_reg == ST_IDLE))
        else $error("trigger walk did not end on the last channel");

    // a new item is taken only when the previous one is done
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !item_ready)
        else $error("item accepted while busy");

endmodule

@@ sv/ser_datapath.sv @@
// ----------------------------------------------------------------------------
// ser_datapath
// Channel state, configuration, width-to-distance multiply and result register.
// ----------------------------------------------------------------------------
module ser_datapath #(
    parameter int NUM_CHANNELS = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ser_pkg::item_t                     item,
    input  logic                               cfg_valid,
    input  logic [ser_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ser_pkg::CFG_W-1:0]          cfg_data,
    input  ser_pkg::ser_cmd_t                  cmd,
    output ser_pkg::ser_status_t               status,
    output logic                               result_valid,
    input  logic                               result_ready,
    output ser_pkg::result_t                   result
);
    import ser_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    // configuration
    logic [31:0]       scale_reg;
    logic [DIST_W-1:0] max_dist_reg;
    logic [31:0]       timeout_reg;

    // per-channel state
    logic [TS_W-1:0]   rise_stamp_reg [NUM_CHANNELS];
    logic [DIST_W-1:0] held_dist_reg  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] held_valid_reg;
    logic [NUM_CHANNELS-1:0] echo_seen_reg;
    // every trigger stamps all channels alike, so one stamp serves them all
    logic [TS_W-1:0]   trig_stamp_reg;

    // working registers
    item_t             item_reg;
    logic [CH_W-1:0]   cur_idx_reg;
    logic [31:0]       prod_reg;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_data_reg;

    logic [TS_W-1:0]   width;
    logic [63:0]       product;
    logic [DIST_W-1:0] clamped;
    logic [TS_W-1:0]   elapsed;
    logic              expired;
    logic              walk_valid;
    logic              load_out;

    assign width   = item_reg.timestamp - rise_stamp_reg[cur_idx_reg];
    assign product = 64'(width) * 64'(scale_reg);
    assign clamped = (prod_reg > 32'(max_dist_reg)) ? max_dist_reg : prod_reg[DIST_W-1:0];

    assign elapsed    = item_reg.timestamp - trig_stamp_reg;
    assign expired    = !echo_seen_reg[cur_idx_reg] && (elapsed >= timeout_reg);
    assign walk_valid = held_valid_reg[cur_idx_reg] && !expired;

    assign load_out = cmd.echo_commit || cmd.trig_step;

    assign status.is_trigger = (item_reg.mode == MODE_TRIGGER);
    assign status.ch_ok      = ({1'b0, item_reg.channel} < 4'(NUM_CHANNELS));
    assign status.is_rise    = (item_reg.level == LEVEL_RISE);
    assign status.last_ch    = (cur_idx_reg == LAST_CH);
    assign status.out_free   = !out_valid_reg || result_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg    <= SCALE_RESET;
            max_dist_reg <= MAX_DIST_RESET;
            timeout_reg  <= TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SCALE:    scale_reg    <= cfg_data;
                CFG_MAX_DIST: max_dist_reg <= cfg_data[DIST_W-1:0];
                CFG_TIMEOUT:  timeout_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // channel state and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                rise_stamp_reg[i] <= '0;
                held_dist_reg[i]  <= '0;
            end
            held_valid_reg <= '0;
            echo_seen_reg  <= '0;
            trig_stamp_reg <= '0;
            cur_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.capture)
            begin
                cur_idx_reg <= (item.mode == MODE_ECHO) ? item.channel[CH_W-1:0] : '0;
            end
            if (cmd.store_rise)
            begin
                rise_stamp_reg[cur_idx_reg] <= item_reg.timestamp;
            end
            if (cmd.echo_commit)
            begin
                held_dist_reg[cur_idx_reg]  <= clamped;
                held_valid_reg[cur_idx_reg] <= 1'b1;
                echo_seen_reg[cur_idx_reg]  <= 1'b1;
            end
            if (cmd.trig_step)
            begin
                held_valid_reg[cur_idx_reg] <= walk_valid;
                echo_seen_reg[cur_idx_reg]  <= 1'b0;
                cur_idx_reg                 <= cur_idx_reg + 1'b1;
                // the stamp must stay old until every channel is checked
                if (status.last_ch)
                begin
                    trig_stamp_reg <= item_reg.timestamp;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.mult)
        begin
            prod_reg <= product[63:32];
        end
        if (cmd.echo_commit)
        begin
            out_data_reg.out_channel   <= OUT_CH_W'(cur_idx_reg);
            out_data_reg.distance_mm   <= clamped;
            out_data_reg.reading_valid <= 1'b1;
            out_data_reg.last_of_run   <= 1'b1;
        end
        else if (cmd.trig_step)
        begin
            out_data_reg.out_channel   <= OUT_CH_W'(cur_idx_reg);
            out_data_reg.distance_mm   <= walk_valid ? held_dist_reg[cur_idx_reg] : '0;
            out_data_reg.reading_valid <= walk_valid;
            out_data_reg.last_of_run   <= status.last_ch;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.reading_valid) |-> (result.distance_mm == '0))
        else $error("invalid reading shows a distance");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.echo_commit |=> (result_valid && result.last_of_run && result.reading_valid))
        else $error("echo result not presented as a valid final item");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.trig_step |=> (echo_seen_reg[$past(cur_idx_reg)] == 1'b0))
        else $error("trigger did not re-arm the channel");

endmodule

@@ sv/multi_channel_sonar_echo_ranger.sv @@
// ----------------------------------------------------------------------------
// multi_channel_sonar_echo_ranger
// Ranges several ultrasonic sensors from timestamped trigger and echo items.
// ----------------------------------------------------------------------------
// A falling edge's result passes through decode, the multiply and the clamp
//   into the result register, in that order; a full result register stalls it.
// One item at a time: a rising edge or dropped channel ends in DECODE, a
//   falling edge goes on through MULT and ECHO_OUT, and a trigger walks the
//   channels one per cycle while the result register is free; a full result
//   register stalls the walk and the echo result.
// Reset (rst_n, async, active low): all channel state cleared, configuration
//   back to its defaults, result register empty. No clearing pass.
// ----------------------------------------------------------------------------
module multi_channel_sonar_echo_ranger #(
    parameter int NUM_CHANNELS = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input items
    input  logic                               item_valid,
    output logic                               item_ready,
    input  ser_pkg::item_t                     item,
    // result items
    output logic                               result_valid,
    input  logic                               result_ready,
    output ser_pkg::result_t                   result,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ser_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ser_pkg::CFG_W-1:0]          cfg_data
);
    import ser_pkg::*;

    ser_cmd_t    cmd;
    ser_status_t status;

    // config registers take a write in any cycle
    assign cfg_ready = 1'b1;

    // Controller: IDLE accepts an item, DECODE classifies it (trigger, bad
    // channel, rising edge, falling edge), then either the multiply and
    // one echo result, or a walk over all channels with one result each.
    ser_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath: per-channel stamps and readings, the 32x32 multiply whose
    // upper word is the distance, clamp, time-out check and result register.
    // The result register decouples the output handshake from input accept.
    ser_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
